// ===== rtl/secure_frame_header_checker_assert.svh =====
// Assertion macros for the frame header checker
`ifndef SECURE_FRAME_HEADER_CHECKER_ASSERT_SVH
`define SECURE_FRAME_HEADER_CHECKER_ASSERT_SVH

// Same-cycle implication, disabled while reset is low
`define SFHC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is low
`define SFHC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/sfhc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfhc_pkg
// Types and constants for the secure frame header checker.
// ----------------------------------------------------------------------------
package sfhc_pkg;

    localparam int unsigned ID_BYTES = 8;
    localparam int unsigned MAX_BODY = 251;
    localparam int unsigned TRL_MIN  = 23;

    localparam logic [6:0] FTYPE_BAD_LO = 7'h00;
    localparam logic [6:0] FTYPE_BAD_HI = 7'h7F;
    localparam logic [6:0] FTYPE_OK     = 7'h4F;
    localparam logic [7:0] TRL_TYPE     = 8'h80;
    localparam logic [9:0] POS_MAX      = 10'd1023;

    // Byte roles
    localparam logic [3:0] ROLE_HEADER   = 4'd0;
    localparam logic [3:0] ROLE_LEAF_ID  = 4'd1;
    localparam logic [3:0] ROLE_BODY_LEN = 4'd2;
    localparam logic [3:0] ROLE_BODY     = 4'd3;
    localparam logic [3:0] ROLE_RESTART  = 4'd4;
    localparam logic [3:0] ROLE_MSG_CNT  = 4'd5;
    localparam logic [3:0] ROLE_TAG      = 4'd6;
    localparam logic [3:0] ROLE_TRL_TYPE = 4'd7;
    localparam logic [3:0] ROLE_TRL_OTH  = 4'd8;
    localparam logic [3:0] ROLE_BEYOND   = 4'd9;

    // Frame status, in check order
    localparam logic [3:0] ST_OK           = 4'd0;
    localparam logic [3:0] ST_SHORT_BUF    = 4'd1;
    localparam logic [3:0] ST_LEN_OVER     = 4'd2;
    localparam logic [3:0] ST_TYPE_RSVD    = 4'd3;
    localparam logic [3:0] ST_TYPE_BAD     = 4'd4;
    localparam logic [3:0] ST_ID_SHORT     = 4'd5;
    localparam logic [3:0] ST_ID_MISMATCH  = 4'd6;
    localparam logic [3:0] ST_BODY_BIG     = 4'd7;
    localparam logic [3:0] ST_BODY_SHORT   = 4'd8;
    localparam logic [3:0] ST_BODY_OVER    = 4'd9;
    localparam logic [3:0] ST_TRL_EMPTY    = 4'd10;
    localparam logic [3:0] ST_INSEC_PAD    = 4'd11;
    localparam logic [3:0] ST_INSECURE     = 4'd12;
    localparam logic [3:0] ST_TRL_SHORT    = 4'd13;
    localparam logic [3:0] ST_TRL_TYPE     = 4'd14;
    localparam logic [3:0] ST_SEQ_MISMATCH = 4'd15;

    typedef struct packed {
        logic [9:0]  pos;
        logic [7:0]  frm_len;
        logic [6:0]  frm_kind;
        logic        secure;
        logic [3:0]  seq;
        logic [3:0]  id_len;
        logic [7:0]  body_size;
        logic        id_mismatch;
        logic [7:0]  trl_type;
        logic [23:0] restart;
        logic [23:0] msg;
        logic [7:0]  end_byte;
    } t_frame;

endpackage

// ===== rtl/secure_frame_header_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// secure_frame_header_checker
// Labels each byte of a received radio frame with its role and reports a
// frame status with the trailer counters on the last byte of the buffer.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel i_valid/o_ready carries one byte (i_frame_byte) and a
//   last-byte flag (i_last_byte). Output channel o_valid/i_ready returns one
//   result per byte: role, the byte itself, and on the last byte the status
//   and the restart and message counters (zero on other bytes).
//   i_cfg_we writes i_cfg_leaf_id as the expected leaf ID; write it only
//   while no request is in flight.
//   A request accepted sits in the input register, and its result is loaded
//   into the output register once that register is free or being read.
//   Throughput: one request per cycle while results are taken; all checks for a
//   byte are done in a single pass between the input and output registers.
//   Reset (i_rst_n low, synchronous) empties both registers, clears the
//   frame state and the leaf ID. A stalled receiver holds the result; the
//   input register still takes one more request, then o_ready drops.
// ----------------------------------------------------------------------------
module secure_frame_header_checker
    import sfhc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [63:0] i_cfg_leaf_id,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_frame_byte,
    input  logic        i_last_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [3:0]  o_byte_role,
    output logic [7:0]  o_byte_value,
    output logic        o_frame_done,
    output logic [3:0]  o_status,
    output logic [23:0] o_restart_count,
    output logic [23:0] o_message_count
);

    `include "secure_frame_header_checker_assert.svh"

    logic [63:0] r_leaf_id;
    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_last;
    logic        r_out_valid;
    logic [3:0]  r_role;
    logic [7:0]  r_value;
    logic        r_done;
    logic [3:0]  r_status;
    logic [23:0] r_restart;
    logic [23:0] r_msg;
    t_frame      r_frm;
    t_frame      n_frm;

    t_frame      upd;
    logic        adv;
    logic        step;
    logic [10:0] pos;
    logic [10:0] num;
    logic [10:0] id_end;
    logic [10:0] t0;
    logic [10:0] toff;
    logic [10:0] flen;
    logic [10:0] blen;
    logic [10:0] ilen;
    logic [3:0]  id_idx;
    logic [7:0]  id_byte;
    logic [3:0]  role;
    logic [3:0]  status;

    assign adv     = !r_out_valid || i_ready;
    assign step    = r_in_valid && adv;
    assign o_ready = !r_in_valid || adv;

    assign id_idx  = r_frm.pos[3:0] - 4'd3;
    assign id_byte = id_idx[3] ? 8'h00 : r_leaf_id[{~id_idx[2:0], 3'b000} +: 8];

    always_comb begin
        upd    = r_frm;
        pos    = {1'b0, r_frm.pos};
        id_end = 11'd3 + {7'd0, r_frm.id_len};
        if (pos == 11'd0) begin
            upd.frm_len = r_in_byte;
        end else if (pos == 11'd1) begin
            upd.frm_kind = r_in_byte[6:0];
            upd.secure   = r_in_byte[7];
        end else if (pos == 11'd2) begin
            upd.seq    = r_in_byte[7:4];
            upd.id_len = r_in_byte[3:0];
        end else if (pos < id_end) begin
            if (r_in_byte != id_byte) begin
                upd.id_mismatch = 1'b1;
            end
        end else if (pos == id_end) begin
            upd.body_size = r_in_byte;
        end

        flen = {3'd0, upd.frm_len};
        blen = {3'd0, upd.body_size};
        ilen = {7'd0, upd.id_len};
        t0   = 11'd4 + ilen + blen;
        toff = pos - t0;

        if (pos >= 11'd3 && pos == flen) begin
            upd.end_byte = r_in_byte;
        end
        if (pos >= t0 && pos <= flen && pos > 11'd2) begin
            if (toff < 11'd3) begin
                upd.restart = {upd.restart[15:0], r_in_byte};
            end else if (toff < 11'd6) begin
                upd.msg = {upd.msg[15:0], r_in_byte};
            end else if (toff == 11'd22) begin
                upd.trl_type = r_in_byte;
            end
        end

        if (pos < 11'd3) begin
            role = ROLE_HEADER;
        end else if (pos > flen) begin
            role = ROLE_BEYOND;
        end else if (pos < 11'd3 + ilen) begin
            role = ROLE_LEAF_ID;
        end else if (pos == 11'd3 + ilen) begin
            role = ROLE_BODY_LEN;
        end else if (pos < t0) begin
            role = ROLE_BODY;
        end else if (toff < 11'd3) begin
            role = ROLE_RESTART;
        end else if (toff < 11'd6) begin
            role = ROLE_MSG_CNT;
        end else if (toff < 11'd22) begin
            role = ROLE_TAG;
        end else if (toff == 11'd22) begin
            role = ROLE_TRL_TYPE;
        end else begin
            role = ROLE_TRL_OTH;
        end

        num = pos + 11'd1;
        if (num <= 11'd4) begin
            status = ST_SHORT_BUF;
        end else if (flen >= num) begin
            status = ST_LEN_OVER;
        end else if (upd.frm_kind == FTYPE_BAD_LO || upd.frm_kind == FTYPE_BAD_HI) begin
            status = ST_TYPE_RSVD;
        end else if (upd.frm_kind != FTYPE_OK) begin
            status = ST_TYPE_BAD;
        end else if (11'd3 + ilen >= num) begin
            status = ST_ID_SHORT;
        end else if (upd.id_mismatch || ilen > 11'(ID_BYTES)) begin
            status = ST_ID_MISMATCH;
        end else if (blen > 11'(MAX_BODY)) begin
            status = ST_BODY_BIG;
        end else if (t0 >= num) begin
            status = ST_BODY_SHORT;
        end else if (blen + 11'd3 >= flen) begin
            status = ST_BODY_OVER;
        end else if (flen <= 11'd3 + blen + ilen) begin
            status = ST_TRL_EMPTY;
        end else if (!upd.secure && (upd.end_byte == 8'h00 || upd.end_byte == 8'hFF)) begin
            status = ST_INSEC_PAD;
        end else if (!upd.secure) begin
            status = ST_INSECURE;
        end else if (flen < 11'd3 + 11'(TRL_MIN) + blen + ilen) begin
            status = ST_TRL_SHORT;
        end else if (upd.trl_type != TRL_TYPE) begin
            status = ST_TRL_TYPE;
        end else if (upd.seq != upd.msg[3:0]) begin
            status = ST_SEQ_MISMATCH;
        end else begin
            status = ST_OK;
        end

        n_frm = upd;
        if (r_in_last) begin
            n_frm = '0;
        end else if (r_frm.pos != POS_MAX) begin
            n_frm.pos = r_frm.pos + 10'd1;
        end else begin
            n_frm.pos = r_frm.pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_leaf_id <= '0;
        end else if (i_cfg_we) begin
            r_leaf_id <= i_cfg_leaf_id;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_frm       <= '0;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (adv) begin
                r_out_valid <= r_in_valid;
            end
            if (step) begin
                r_frm <= n_frm;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in_byte <= i_frame_byte;
            r_in_last <= i_last_byte;
        end
        if (step) begin
            r_role    <= role;
            r_value   <= r_in_byte;
            r_done    <= r_in_last;
            r_status  <= r_in_last ? status : ST_OK;
            r_restart <= r_in_last ? upd.restart : 24'd0;
            r_msg     <= r_in_last ? upd.msg : 24'd0;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_byte_role     = r_role;
    assign o_byte_value    = r_value;
    assign o_frame_done    = r_done;
    assign o_status        = r_status;
    assign o_restart_count = r_restart;
    assign o_message_count = r_msg;

    `SFHC_ASSERT_NOW(a_idle_zero, i_clk, i_rst_n,
        o_valid && !o_frame_done,
        o_status == ST_OK && o_restart_count == 24'd0 && o_message_count == 24'd0,
        "status or counters set on a byte that is not last")
    `SFHC_ASSERT_NEXT(a_frame_clear, i_clk, i_rst_n,
        step && r_in_last,
        r_frm == '0,
        "frame state not cleared after last byte")
    `SFHC_ASSERT_NEXT(a_header_role, i_clk, i_rst_n,
        step && r_frm.pos < 10'd3,
        o_valid && o_byte_role == ROLE_HEADER,
        "first three bytes not labeled as header")
    `SFHC_ASSERT_NOW(a_stall_cause, i_clk, i_rst_n,
        !o_ready,
        r_in_valid && r_out_valid && !i_ready,
        "input stalled without a full pipeline")

endmodule

// ===== tb/frame_status_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_status_checker
// Watches the request and result channels of the secure frame header checker.
// Tracks the frame state and the configured leaf ID, predicts the role and
// final status of every accepted byte, and compares each accepted result
// field by field with the oldest prediction. Reports the mismatch count and
// the number of results still owed.
// ----------------------------------------------------------------------------
module frame_status_checker
    import sfhc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [63:0] i_cfg_leaf_id,
    input  logic        i_req_valid,
    input  logic        i_req_ready,
    input  logic [7:0]  i_frame_byte,
    input  logic        i_last_byte,
    input  logic        i_rsp_valid,
    input  logic        i_rsp_ready,
    input  logic [3:0]  i_byte_role,
    input  logic [7:0]  i_byte_value,
    input  logic        i_frame_done,
    input  logic [3:0]  i_status,
    input  logic [23:0] i_restart_count,
    input  logic [23:0] i_message_count,
    output int          o_fail_count,
    output int          o_outstanding
);

    localparam logic [7:0] PAD_ZEROS = 8'h00;
    localparam logic [7:0] PAD_ONES  = 8'hFF;

    typedef struct packed {
        logic [9:0]  pos;
        logic [7:0]  flen;
        logic [6:0]  ftype;
        logic        secure;
        logic [3:0]  seq;
        logic [3:0]  id_len;
        logic [7:0]  body_size;
        logic        id_mis;
        logic [7:0]  trl_type;
        logic [23:0] restart;
        logic [23:0] msg;
        logic [7:0]  end_byte;
    } t_frame_state;

    typedef struct packed {
        logic [3:0]  role;
        logic [7:0]  value;
        logic        done;
        logic [3:0]  status;
        logic [23:0] restart;
        logic [23:0] msg;
    } t_byte_result;

    t_frame_state rx_frame;
    logic [63:0]  leaf_id;
    t_byte_result expected_results[$];
    int           mismatches;

    initial begin
        o_fail_count  = 0;
        o_outstanding = 0;
        mismatches    = 0;
        rx_frame      = '0;
        leaf_id       = '0;
    end

    function automatic logic [7:0] expected_id_byte(input int idx);
        if (idx < ID_BYTES) return leaf_id[63 - 8 * idx -: 8];
        return 8'h00;
    endfunction

    function automatic logic [3:0] frame_status(input int num);
        int flen, idl, bl, tl;
        flen = rx_frame.flen;
        idl  = rx_frame.id_len;
        bl   = rx_frame.body_size;
        tl   = flen - 3 - bl - idl;
        if (num <= 4) return ST_SHORT_BUF;
        if (flen >= num) return ST_LEN_OVER;
        if (rx_frame.ftype == FTYPE_BAD_LO || rx_frame.ftype == FTYPE_BAD_HI)
            return ST_TYPE_RSVD;
        if (rx_frame.ftype != FTYPE_OK) return ST_TYPE_BAD;
        if (3 + idl >= num) return ST_ID_SHORT;
        if (rx_frame.id_mis || idl > int'(ID_BYTES)) return ST_ID_MISMATCH;
        if (bl > int'(MAX_BODY)) return ST_BODY_BIG;
        if (4 + idl + bl >= num) return ST_BODY_SHORT;
        if (bl + 3 >= flen) return ST_BODY_OVER;
        if (tl <= 0) return ST_TRL_EMPTY;
        if (!rx_frame.secure &&
            (rx_frame.end_byte == PAD_ZEROS || rx_frame.end_byte == PAD_ONES))
            return ST_INSEC_PAD;
        if (!rx_frame.secure) return ST_INSECURE;
        if (tl < int'(TRL_MIN)) return ST_TRL_SHORT;
        if (rx_frame.trl_type != TRL_TYPE) return ST_TRL_TYPE;
        if (rx_frame.seq != rx_frame.msg[3:0]) return ST_SEQ_MISMATCH;
        return ST_OK;
    endfunction

    function automatic t_byte_result advance_frame(input logic [7:0] b, input logic last);
        t_byte_result r;
        int p, idl, flen, t0, t;
        p = rx_frame.pos;
        if (p == 0) begin
            rx_frame.flen = b;
        end else if (p == 1) begin
            rx_frame.ftype  = b[6:0];
            rx_frame.secure = b[7];
        end else if (p == 2) begin
            rx_frame.seq    = b[7:4];
            rx_frame.id_len = b[3:0];
        end else if (p < 3 + int'(rx_frame.id_len)) begin
            if (b != expected_id_byte(p - 3)) rx_frame.id_mis = 1'b1;
        end else if (p == 3 + int'(rx_frame.id_len)) begin
            rx_frame.body_size = b;
        end

        idl  = rx_frame.id_len;
        flen = rx_frame.flen;
        t0   = 4 + idl + int'(rx_frame.body_size);
        if (p >= 3 && p == flen) rx_frame.end_byte = b;
        if (p >= t0 && p <= flen && p > 2) begin
            t = p - t0;
            if (t < 3)       rx_frame.restart  = {rx_frame.restart[15:0], b};
            else if (t < 6)  rx_frame.msg      = {rx_frame.msg[15:0], b};
            else if (t == 22) rx_frame.trl_type = b;
        end

        if (p < 3) begin
            r.role = ROLE_HEADER;
        end else if (p > flen) begin
            r.role = ROLE_BEYOND;
        end else if (p < 3 + idl) begin
            r.role = ROLE_LEAF_ID;
        end else if (p == 3 + idl) begin
            r.role = ROLE_BODY_LEN;
        end else if (p < t0) begin
            r.role = ROLE_BODY;
        end else begin
            t = p - t0;
            if (t < 3)        r.role = ROLE_RESTART;
            else if (t < 6)   r.role = ROLE_MSG_CNT;
            else if (t < 22)  r.role = ROLE_TAG;
            else if (t == 22) r.role = ROLE_TRL_TYPE;
            else              r.role = ROLE_TRL_OTH;
        end

        r.value   = b;
        r.done    = last;
        r.status  = '0;
        r.restart = '0;
        r.msg     = '0;
        if (last) begin
            r.status  = frame_status(p + 1);
            r.restart = rx_frame.restart;
            r.msg     = rx_frame.msg;
            rx_frame  = '0;
        end else if (rx_frame.pos < POS_MAX) begin
            rx_frame.pos = rx_frame.pos + 10'd1;
        end
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_byte_result want;
        if (!i_rst_n) begin
            rx_frame = '0;
            leaf_id  = '0;
            expected_results.delete();
        end else begin
            if (i_cfg_we) leaf_id = i_cfg_leaf_id;
            if (i_req_valid && i_req_ready)
                expected_results.push_back(advance_frame(i_frame_byte, i_last_byte));
            if (i_rsp_valid && i_rsp_ready) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result: role %0d value %0h", i_byte_role,
                           i_byte_value);
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("byte_role", want.role, i_byte_role);
                    check_field("byte_value", want.value, i_byte_value);
                    check_field("frame_done", want.done, i_frame_done);
                    check_field("status", want.status, i_status);
                    check_field("restart_count", want.restart, i_restart_count);
                    check_field("message_count", want.msg, i_message_count);
                end
            end
        end
        o_fail_count  <= mismatches;
        o_outstanding <= expected_results.size();
    end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives byte requests into the secure frame header checker: a few hand-made
// buffers for the corner cases, then phases of random frames under several
// leaf IDs, mostly frames built well-formed, many with faults injected, and some
// pure noise. Both channels idle at random; the checker module judges every
// result.
// ----------------------------------------------------------------------------
module tb_top
    import sfhc_pkg::*;
();

    localparam int unsigned CYCLE_LIMIT = 400000;

    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_we      = 1'b0;
    logic [63:0] i_cfg_leaf_id = '0;
    logic        i_valid       = 1'b0;
    logic [7:0]  i_frame_byte  = '0;
    logic        i_last_byte   = 1'b0;
    logic        i_ready       = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic [3:0]  o_byte_role;
    logic [7:0]  o_byte_value;
    logic        o_frame_done;
    logic [3:0]  o_status;
    logic [23:0] o_restart_count;
    logic [23:0] o_message_count;

    int          fail_count;
    int          outstanding;
    int unsigned cycle_count = 0;

    logic [7:0]  frame_bytes[$];
    logic [63:0] leaf_id_cfg = '0;
    bit          tx_steady   = 1'b0;
    int          items_sent  = 0;

    secure_frame_header_checker dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_leaf_id   (i_cfg_leaf_id),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_frame_byte    (i_frame_byte),
        .i_last_byte     (i_last_byte),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_byte_role     (o_byte_role),
        .o_byte_value    (o_byte_value),
        .o_frame_done    (o_frame_done),
        .o_status        (o_status),
        .o_restart_count (o_restart_count),
        .o_message_count (o_message_count)
    );

    frame_status_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_leaf_id   (i_cfg_leaf_id),
        .i_req_valid     (i_valid),
        .i_req_ready     (o_ready),
        .i_frame_byte    (i_frame_byte),
        .i_last_byte     (i_last_byte),
        .i_rsp_valid     (o_valid),
        .i_rsp_ready     (i_ready),
        .i_byte_role     (o_byte_role),
        .i_byte_value    (o_byte_value),
        .i_frame_done    (o_frame_done),
        .i_status        (o_status),
        .i_restart_count (o_restart_count),
        .i_message_count (o_message_count),
        .o_fail_count    (fail_count),
        .o_outstanding   (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic send_request(input logic [7:0] b, input logic last);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_frame_byte <= b;
        i_last_byte  <= last;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic send_frame();
        foreach (frame_bytes[i])
            send_request(frame_bytes[i], i == frame_bytes.size() - 1);
    endtask

    // Drain all results before touching the leaf ID.
    task automatic write_leaf_id(input logic [63:0] value);
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_we      <= 1'b1;
        i_cfg_leaf_id <= value;
        @(posedge i_clk);
        i_cfg_we      <= 1'b0;
        leaf_id_cfg = value;
    endtask

    function automatic void build_random_frame();
        int         id_len, body_size, fault, idx;
        logic [23:0] restart, msg;
        logic [7:0] tmp;
        frame_bytes.delete();
        if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 12)) frame_bytes.push_back(8'($urandom));
            return;
        end
        id_len    = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 15) : $urandom_range(0, 8);
        body_size = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 80) : $urandom_range(0, 6);
        restart   = 24'($urandom);
        msg       = 24'($urandom);
        frame_bytes.push_back(8'(26 + id_len + body_size));
        frame_bytes.push_back({1'b1, FTYPE_OK});
        frame_bytes.push_back({msg[3:0], 4'(id_len)});
        for (int i = 0; i < id_len; i++)
            frame_bytes.push_back(i < ID_BYTES ? leaf_id_cfg[63 - 8 * i -: 8] : 8'h00);
        frame_bytes.push_back(8'(body_size));
        repeat (body_size) frame_bytes.push_back(8'($urandom));
        frame_bytes.push_back(restart[23:16]);
        frame_bytes.push_back(restart[15:8]);
        frame_bytes.push_back(restart[7:0]);
        frame_bytes.push_back(msg[23:16]);
        frame_bytes.push_back(msg[15:8]);
        frame_bytes.push_back(msg[7:0]);
        repeat (16) frame_bytes.push_back(8'($urandom));
        frame_bytes.push_back(TRL_TYPE);

        fault = $urandom_range(0, 15);
        case (fault)
            6: begin
                tmp = frame_bytes[1];
                tmp[6:0] = ($urandom_range(0, 1) == 0) ?
                           (($urandom_range(0, 1) == 0) ? FTYPE_BAD_LO : FTYPE_BAD_HI) :
                           7'($urandom);
                frame_bytes[1] = tmp;
            end
            7: begin
                tmp = frame_bytes[1];
                tmp[7] = 1'b0;
                frame_bytes[1] = tmp;
                case ($urandom_range(0, 2))
                    0: frame_bytes[frame_bytes.size() - 1] = 8'h00;
                    1: frame_bytes[frame_bytes.size() - 1] = 8'hFF;
                    default: ;
                endcase
            end
            8: begin
                if (id_len > 0) begin
                    idx = 3 + $urandom_range(0, id_len - 1);
                    frame_bytes[idx] = frame_bytes[idx] ^ 8'(1 << $urandom_range(0, 7));
                end else begin
                    frame_bytes[0] = 8'($urandom_range(0, 40));
                end
            end
            9: begin
                tmp = frame_bytes[2];
                tmp[7:4] = tmp[7:4] ^ 4'($urandom_range(1, 15));
                frame_bytes[2] = tmp;
            end
            10: frame_bytes[frame_bytes.size() - 1] = 8'($urandom);
            11: repeat ($urandom_range(1, frame_bytes.size() - 1)) void'(frame_bytes.pop_back());
            12: repeat ($urandom_range(1, 10)) frame_bytes.push_back(8'($urandom));
            13: frame_bytes[0] = 8'($urandom);
            14: frame_bytes[3 + id_len] = 8'($urandom_range(252, 255));
            15: frame_bytes[3 + id_len] = 8'($urandom);
            default: ;
        endcase
    endfunction

    // Result side: draw a stall before each result, with steady stretches.
    initial begin
        int gap, served;
        bit rx_steady;
        served    = 0;
        rx_steady = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (served % 50 == 0) rx_steady = ($urandom_range(0, 3) == 0);
            gap = rx_steady ? 0 : $urandom_range(0, 9);
            if (gap > 0) begin
                i_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
            served++;
        end
    end

    initial begin
        logic [63:0] phase_ids[4];
        phase_ids[0] = 64'hFFFF_FFFF_FFFF_FFFF;
        phase_ids[1] = {$urandom, $urandom};
        phase_ids[2] = 64'h0;
        phase_ids[3] = {$urandom, $urandom};

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_leaf_id(64'h0);

        // short buffer
        frame_bytes = '{8'hFF};
        send_frame();
        // reserved frame type, all-ones second and third bytes
        frame_bytes = '{8'h00, 8'hFF, 8'hFF, 8'h00, 8'h00};
        send_frame();
        // frame length of 3, bytes past the frame
        frame_bytes = '{8'h03, 8'h4F, 8'h00, 8'h00, 8'h00, 8'h00};
        send_frame();
        // leaf ID fills the frame length, body length byte lies past it
        frame_bytes = '{8'h04, 8'h4F, 8'h02, 8'h00, 8'h00, 8'h00, 8'h00};
        send_frame();
        // insecure frame ending in a zero byte
        frame_bytes = '{8'h05, 8'h4F, 8'h00, 8'h00, 8'hAA, 8'h00};
        send_frame();

        for (int ph = 0; ph < 4; ph++) begin
            write_leaf_id(phase_ids[ph]);
            while (items_sent < 25 + 130 * (ph + 1)) begin
                build_random_frame();
                tx_steady = ($urandom_range(0, 3) == 0);
                send_frame();
            end
        end

        i_valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
